// ===== hdl/ptpm_pkg.sv =====
// Package for the priority table with promote and pop-max.
// Holds sizes, command and status codes, beat and internal port types.
// No dependencies.
package ptpm_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int PRIO_W = 16;
  localparam int PAY_W  = 32;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_PROMOTE = 3'd1;
  localparam logic [2:0] CMD_LOOKUP  = 3'd2;
  localparam logic [2:0] CMD_PEEK    = 3'd3;
  localparam logic [2:0] CMD_POP     = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_BADID = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [IDX_W-1:0] entry_id;
    logic [PAY_W-1:0] payload_in;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  result_id;
    logic [PAY_W-1:0]  payload_out;
    logic [PRIO_W-1:0] priority_out;
    logic              is_valid;
  } out_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [PAY_W-1:0]  payload;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           entry;
  } mem_wr_t;

  typedef struct packed {
    logic [PRIO_W-1:0] cand_prio;
    logic              cand_valid;
    logic [PRIO_W-1:0] best_prio;
    logic              best_found;
  } alu_req_t;

  typedef struct packed {
    logic              take;
    logic [PRIO_W-1:0] inc;
  } alu_res_t;

endpackage

// ===== hdl/ptpm_mem.sv =====
// Entry store: priority and payload of every table entry.
// One write port, one read port with registered read data. Uses ptpm_pkg.
module ptpm_mem import ptpm_pkg::*; (
  input  logic             clk,
  input  mem_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/ptpm_alu.sv =====
// Shared priority unit: compare against the running best and saturating increment.
// Used by the max scan and by promote. Uses ptpm_pkg.
module ptpm_alu import ptpm_pkg::*; (
  input  alu_req_t req,
  output alu_res_t res
);

  always_comb begin
    // ties go to the later entry, so take on greater or equal
    res.take = req.cand_valid && (!req.best_found || (req.cand_prio >= req.best_prio));
    res.inc  = (req.cand_prio == {PRIO_W{1'b1}}) ? req.cand_prio
                                                 : req.cand_prio + 1'b1;
  end

endmodule

// ===== hdl/priority_table_promote_pop_max_unit.sv =====
// Top level of the priority table: sequencer, valid bits, id counter, result register.
// Instantiates ptpm_mem and ptpm_alu. Uses ptpm_pkg.
//
//   channel | direction | handshake         | beat
//   in      | input     | in_valid/in_stall   | in_t  (cmd, entry_id, payload_in)
//   out     | output    | out_valid/out_stall | out_t (status, id, payload, priority, valid)
//
// Add, invalid ids and unknown commands pass through S_EXEC and S_FIN; lookup and promote
// also pass through S_RD. Peek and pop scan every entry in S_SCAN: the scan reads one
// entry per cycle through the single read port of the entry store.
// One item at a time: in_stall is high from accept until the result is in the out register.
// A stalled result holds in the out register; the sequencer waits before loading the next.
// Synchronous active-low reset clears valid bits and the id counter at once.
module priority_table_promote_pop_max_unit import ptpm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_RD   = 5'b00100,
    S_SCAN = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        cmd_r, cmd_nxt;
  logic [IDX_W-1:0]  id_r, id_nxt;
  logic [PAY_W-1:0]  pay_r, pay_nxt;
  logic [DEPTH-1:0]  valid_r, valid_nxt;
  logic [CNT_W-1:0]  next_id_r, next_id_nxt;
  logic [IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [PRIO_W-1:0] best_prio_r, best_prio_nxt;
  logic [PAY_W-1:0]  best_pay_r, best_pay_nxt;
  out_t              res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  mem_wr_t           wr;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            rd_data;
  alu_req_t          alu_req;
  alu_res_t          alu_res;

  ptpm_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    alu_req.cand_prio  = rd_data.prio;
    alu_req.cand_valid = valid_r[rd_idx_r];
    alu_req.best_prio  = best_prio_r;
    alu_req.best_found = found_r;
  end

  ptpm_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    pay_nxt       = pay_r;
    valid_nxt     = valid_r;
    next_id_nxt   = next_id_r;
    scan_idx_nxt  = scan_idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_prio_nxt = best_prio_r;
    best_pay_nxt  = best_pay_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rd_addr       = id_r;
    wr            = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.cmd;
          id_nxt    = in_data.entry_id;
          pay_nxt   = in_data.payload_in;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt   = '0;
        state_nxt = S_FIN;
        unique case (cmd_r)
          CMD_ADD: begin
            if (next_id_r == CNT_W'(DEPTH)) begin
              res_nxt.status = ST_FULL;
            end else begin
              wr.en                  = 1'b1;
              wr.addr                = next_id_r[IDX_W-1:0];
              wr.entry.prio          = '0;
              wr.entry.payload       = pay_r;
              valid_nxt[next_id_r[IDX_W-1:0]] = 1'b1;
              next_id_nxt            = next_id_r + 1'b1;
              res_nxt.result_id      = next_id_r[IDX_W-1:0];
            end
          end
          CMD_PROMOTE, CMD_LOOKUP: begin
            res_nxt.result_id = id_r;
            if (!valid_r[id_r]) begin
              res_nxt.status = ST_BADID;
            end else begin
              rd_addr   = id_r;
              state_nxt = S_RD;
            end
          end
          CMD_PEEK, CMD_POP: begin
            // prime the read pipe with entry 0
            rd_addr      = '0;
            scan_idx_nxt = IDX_W'(1);
            found_nxt    = 1'b0;
            state_nxt    = S_SCAN;
          end
          default: begin
          end
        endcase
      end
      S_RD: begin
        res_nxt.status      = ST_OK;
        res_nxt.payload_out = rd_data.payload;
        res_nxt.is_valid    = 1'b1;
        if (cmd_r == CMD_PROMOTE) begin
          wr.en                = 1'b1;
          wr.addr              = id_r;
          wr.entry.prio        = alu_res.inc;
          wr.entry.payload     = rd_data.payload;
          res_nxt.priority_out = alu_res.inc;
        end else begin
          res_nxt.priority_out = rd_data.prio;
        end
        state_nxt = S_FIN;
      end
      S_SCAN: begin
        rd_addr      = scan_idx_r;
        scan_idx_nxt = scan_idx_r + 1'b1;
        if (alu_res.take) begin
          found_nxt     = 1'b1;
          best_idx_nxt  = rd_idx_r;
          best_prio_nxt = rd_data.prio;
          best_pay_nxt  = rd_data.payload;
        end
        if (rd_idx_r == IDX_W'(DEPTH - 1)) begin
          res_nxt   = '0;
          state_nxt = S_FIN;
          if (found_nxt) begin
            res_nxt.status       = ST_OK;
            res_nxt.result_id    = best_idx_nxt;
            res_nxt.payload_out  = best_pay_nxt;
            res_nxt.priority_out = best_prio_nxt;
            res_nxt.is_valid     = 1'b1;
            if (cmd_r == CMD_POP) begin
              valid_nxt[best_idx_nxt] = 1'b0;
            end
          end else begin
            res_nxt.status = ST_EMPTY;
          end
        end
      end
      S_FIN: begin
        // hold until the out register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      next_id_r   <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      next_id_r   <= next_id_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    id_r        <= id_nxt;
    pay_r       <= pay_nxt;
    scan_idx_r  <= scan_idx_nxt;
    rd_idx_r    <= rd_addr;
    best_idx_r  <= best_idx_nxt;
    best_prio_r <= best_prio_nxt;
    best_pay_r  <= best_pay_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_next_id_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r <= CNT_W'(DEPTH))
    else $error("id counter ran past the table depth");

  a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && cmd_r == CMD_ADD && next_id_r != CNT_W'(DEPTH))
    |=> next_id_r == $past(next_id_r) + 1'b1)
    else $error("accepted add did not advance the id counter");

  a_best_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && found_r) |-> valid_r[best_idx_r])
    else $error("scan holds a best entry that is not valid");

  a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && (!out_valid_r || !out_stall))
    |=> (state_r == S_IDLE && out_valid_r))
    else $error("result not handed to the out register");
`endif

endmodule
